@@ hdl/sdq_pkg.sv @@
// Package for the sorted double-ended queue: command and status codes,
// the result record and shared widths. No dependencies.
`default_nettype none

package sdq_pkg;

  localparam int VAL_W = 32;
  localparam int CNT_W = 5;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_POP_MIN = 2'd1;
  localparam logic [1:0] CMD_POP_MAX = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [VAL_W-1:0] NO_VALUE = '1;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/sdq_mem.sv @@
// Entry store: one write port, one read port, registered read data.
// Depends on nothing.
`default_nettype none

module sdq_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/sdq_ctrl.sv @@
// Sequencer for the sorted queue: circular window over the entry store,
// insert by shifting from the top down. Uses sdq_pkg.
`default_nettype none

module sdq_ctrl #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cmd_valid,
  output logic                                cmd_ready,
  input  wire logic [1:0]                     cmd_code,
  input  wire logic [sdq_pkg::VAL_W-1:0]      cmd_value,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output sdq_pkg::result_t                    res,
  output logic      [CW-1:0]                  held_cnt,
  output logic                                mem_we,
  output logic      [AW-1:0]                  mem_waddr,
  output logic      [sdq_pkg::VAL_W-1:0]      mem_wdata,
  output logic                                mem_re,
  output logic      [AW-1:0]                  mem_raddr,
  input  wire logic [sdq_pkg::VAL_W-1:0]      mem_rdata
);

  import sdq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_PUT  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    head_r,  head_nxt;
  logic [CW-1:0]    cnt_r,   cnt_nxt;
  logic [AW-1:0]    idx_r,   idx_nxt;
  logic [VAL_W-1:0] val_r,   val_nxt;
  result_t          res_r,   res_nxt;

  // logical slot -> physical address, window starts at head
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [AW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, hd} + {1'b0, l};
    if (s >= (AW+1)'(CAPACITY)) begin
      s = s - (AW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  logic [CW-1:0] cnt_inc, cnt_dec;
  logic [AW-1:0] top_idx;
  logic          keep_shift;

  assign cnt_inc    = cnt_r + CW'(1);
  assign cnt_dec    = cnt_r - CW'(1);
  assign top_idx    = AW'(cnt_dec);
  assign keep_shift = !($signed(mem_rdata) < $signed(val_r));

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    res_nxt   = res_r;
    cmd_ready = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = phys(head_r, idx_r + AW'(1));
    mem_wdata = val_r;
    mem_re    = 1'b0;
    mem_raddr = phys(head_r, top_idx);

    case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          val_nxt = cmd_value;
          case (cmd_code)
            CMD_INSERT: begin
              if (cnt_r == CW'(CAPACITY)) begin
                res_nxt   = '{value: NO_VALUE, status: ST_FULL, count: CNT_W'(cnt_r)};
                state_nxt = S_DONE;
              end else if (cnt_r == '0) begin
                mem_we    = 1'b1;
                mem_waddr = head_r;
                mem_wdata = cmd_value;
                cnt_nxt   = cnt_inc;
                res_nxt   = '{value: NO_VALUE, status: ST_OK, count: CNT_W'(cnt_inc)};
                state_nxt = S_DONE;
              end else begin
                mem_re    = 1'b1;
                idx_nxt   = top_idx;
                state_nxt = S_INS;
              end
            end
            CMD_POP_MIN, CMD_POP_MAX: begin
              if (cnt_r == '0) begin
                res_nxt   = '{value: NO_VALUE, status: ST_EMPTY, count: CNT_W'(cnt_r)};
                state_nxt = S_DONE;
              end else begin
                mem_re  = 1'b1;
                cnt_nxt = cnt_dec;
                if (cmd_code == CMD_POP_MIN) begin
                  mem_raddr = head_r;
                  head_nxt  = phys(head_r, AW'(1));
                end
                state_nxt = S_RD;
              end
            end
            default: begin
              res_nxt   = '{value: NO_VALUE, status: ST_OK, count: CNT_W'(cnt_r)};
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RD: begin
        res_nxt   = '{value: mem_rdata, status: ST_OK, count: CNT_W'(cnt_r)};
        state_nxt = S_DONE;
      end
      S_INS: begin
        // write slot idx+1 while reading idx-1: addresses never coincide
        mem_we = 1'b1;
        if (keep_shift) begin
          mem_wdata = mem_rdata;
          if (idx_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = phys(head_r, idx_r - AW'(1));
            idx_nxt   = idx_r - AW'(1);
          end
        end else begin
          cnt_nxt   = cnt_inc;
          res_nxt   = '{value: NO_VALUE, status: ST_OK, count: CNT_W'(cnt_inc)};
          state_nxt = S_DONE;
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = head_r;
        cnt_nxt   = cnt_inc;
        res_nxt   = '{value: NO_VALUE, status: ST_OK, count: CNT_W'(cnt_inc)};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    res_r <= res_nxt;
  end

  assign res      = res_r;
  assign held_cnt = cnt_r;

endmodule

`default_nettype wire

@@ hdl/sorted_double_ended_queue.sv @@
// Top level of the sorted double-ended queue: sequencer, entry store and
// the output word register. Uses sdq_pkg, sdq_ctrl, sdq_mem.
`default_nettype none

// Channel | dir | tdata (low bit up)                  | tuser
// in_     | in  | value[31:0]                         | command[1:0]
// out_    | out | result_value[31:0], entry_count[36:32], zero pad | status[1:0]
//
// A pop reads one entry before hand-off; an insert into a non-empty store reads and shifts up
//   each held entry not below the new value; the entry store's single read port sets the pace.
// Empty pop, full insert, insert into an empty store and unknown commands
//   go straight from idle to hand-off.
// Reset clears the count and window pointer; entry contents need no clearing.
// A finished word waits in the output register while the next word is taken.
module sorted_double_ended_queue #(
  parameter int CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // value[31:0]
  input  wire logic [1:0]  in_tuser,   // command[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // result_value[31:0], entry_count[36:32], zeros
  output logic      [1:0]  out_tuser   // status[1:0]
);

  import sdq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic             res_valid, res_ready;
  result_t          res;
  logic [CW-1:0]    held_cnt;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [VAL_W-1:0] mem_wdata, mem_rdata;

  sdq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd_code  (in_tuser),
    .cmd_value (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .held_cnt  (held_cnt),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  sdq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (VAL_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output word register
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r,   out_res_nxt;

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.count, out_res_r.value};
  assign out_tuser  = out_res_r.status;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt <= CW'(CAPACITY))
    else $error("held count above capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second command taken while one is in progress");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_FULL) |-> out_tdata[36:32] == CNT_W'(CAPACITY))
    else $error("full status with count below capacity");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_EMPTY) |->
      (out_tdata[36:32] == '0 && out_tdata[31:0] == NO_VALUE))
    else $error("empty status with non-empty word");
`endif

endmodule

`default_nettype wire

@@ dv/tb_sorted_double_ended_queue.sv @@
`timescale 1ns / 1ps
// Testbench for sorted_double_ended_queue: directed and random command streams
// checked word by word against a shadow sorted list. Depends on sdq_pkg and the RTL.

module tb_sorted_double_ended_queue;
  import sdq_pkg::*;

  localparam int          DEPTH      = 16;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;   // spare code, block must ignore it
  localparam logic [31:0] INT_MIN    = 32'h8000_0000;
  localparam logic [31:0] INT_MAX    = 32'h7fff_ffff;
  localparam int          IDLE_PCT   = 17;
  localparam int          MAX_REPORT = 100;

  // DUT connections; every input starts at a known value
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // value[31:0]
  logic [1:0]  in_tuser   = '0;   // command[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // result_value[31:0], entry_count[36:32], zero pad
  logic [1:0]  out_tuser;         // status[1:0]

  // shadow of the block: held values ascending, and words still to come
  logic signed [31:0] shadow_vals[$];
  result_t            pending_words[$];

  bit gaps_on     = 1'b1;   // random idling on both sides
  int hold_cycles = 0;      // receiver hold-off, counted down by the receiver
  int errors      = 0;
  int words_sent  = 0;
  int words_seen  = 0;
  int full_seen   = 0;
  int empty_seen  = 0;

  sorted_double_ended_queue #(.CAPACITY(DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // run limit, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("%0t ns: timeout, %0d words still expected", $time, pending_words.size());
    $display("TB_ERROR");
    $finish;
  end

  // Apply one accepted command to the shadow list and queue its result word.
  task automatic apply_command(input logic [1:0] cmd, input logic [31:0] val);
    result_t w;
    int      pos;
    w.value  = NO_VALUE;
    w.status = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_vals.size() >= DEPTH) begin
          w.status = ST_FULL;
        end else begin
          // new value goes ahead of equal ones: first slot not below it
          pos = 0;
          while (pos < shadow_vals.size() && shadow_vals[pos] < $signed(val)) pos++;
          shadow_vals.insert(pos, $signed(val));
        end
      end
      CMD_POP_MIN: begin
        if (shadow_vals.size() == 0) begin
          w.status = ST_EMPTY;
        end else begin
          w.value = shadow_vals[0];
          shadow_vals.delete(0);
        end
      end
      CMD_POP_MAX: begin
        if (shadow_vals.size() == 0) begin
          w.status = ST_EMPTY;
        end else begin
          w.value = shadow_vals[$];
          shadow_vals.delete(shadow_vals.size() - 1);
        end
      end
      default: ;  // unused code: nothing changes
    endcase
    w.count = CNT_W'(shadow_vals.size());
    pending_words.push_back(w);
  endtask

  // Offer one command word, optionally after a random gap, and wait for it to go in.
  task automatic send_word(input logic [1:0] cmd, input logic [31:0] val);
    int gap;
    if (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      gap = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= val;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    apply_command(cmd, val);
    words_sent++;
  endtask

  // Sender stops and waits until every queued result word has been seen.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // Values weighted towards the extremes and a narrow band that forces ties.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return INT_MIN;
      1:       return INT_MAX;
      2, 3, 4: return $urandom_range(0, 7) - 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic void report_mismatch(string what, logic [39:0] want, logic [39:0] got);
    errors++;
    if (errors <= MAX_REPORT)
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endfunction

  // Receiver: checks each accepted word, then drives ready for the next edge.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", '0, {out_tuser, out_tdata[37:0]});
      end else begin
        want = pending_words[0];
        pending_words.delete(0);
        if (want.status == ST_FULL)  full_seen++;
        if (want.status == ST_EMPTY) empty_seen++;
        if (out_tdata[31:0] !== want.value)
          report_mismatch("result_value", 40'(want.value), 40'(out_tdata[31:0]));
        if (out_tdata[36:32] !== want.count)
          report_mismatch("entry_count", 40'(want.count), 40'(out_tdata[36:32]));
        if (out_tdata[39:37] !== 3'b000)
          report_mismatch("tdata pad", '0, 40'(out_tdata[39:37]));
        if (out_tuser !== want.status)
          report_mismatch("status", 40'(want.status), 40'(out_tuser));
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_tready <= 1'b0;
    end else if (gaps_on) begin
      out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Pops and the spare code on an empty store.
  task automatic test_empty_store();
    send_word(CMD_POP_MIN, $urandom);
    send_word(CMD_POP_MAX, $urandom);
    send_word(CMD_UNUSED, $urandom);
  endtask

  // Extreme values, zero, minus one and a pair of equal values, then both ends off.
  task automatic test_extremes_and_ties();
    send_word(CMD_INSERT, INT_MAX);
    send_word(CMD_INSERT, INT_MIN);
    send_word(CMD_INSERT, 32'd0);
    send_word(CMD_INSERT, 32'hffff_ffff);
    send_word(CMD_INSERT, 32'd5);
    send_word(CMD_INSERT, 32'd5);
    send_word(CMD_UNUSED, 32'hffff_ffff);
    send_word(CMD_POP_MIN, 32'd0);
    send_word(CMD_POP_MAX, 32'hffff_ffff);
    send_word(CMD_POP_MAX, 32'd0);
    send_word(CMD_POP_MIN, 32'd0);
    send_word(CMD_POP_MAX, 32'd0);
    send_word(CMD_POP_MIN, 32'd0);
    send_word(CMD_POP_MIN, 32'd0);
  endtask

  // Fill to capacity back to back, overflow it, then empty it past zero.
  task automatic test_fill_and_overflow();
    int i;
    gaps_on = 1'b0;
    for (i = 0; i < DEPTH; i++) send_word(CMD_INSERT, pick_value());
    send_word(CMD_INSERT, INT_MIN);
    send_word(CMD_INSERT, INT_MAX);
    send_word(CMD_UNUSED, $urandom);
    send_word(CMD_POP_MAX, $urandom);
    send_word(CMD_INSERT, pick_value());
    send_word(CMD_INSERT, pick_value());
    for (i = 0; i < DEPTH + 1; i++)
      send_word($urandom_range(0, 1) ? CMD_POP_MIN : CMD_POP_MAX, $urandom);
    gaps_on = 1'b1;
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the block stalls its input; then the sender waits for every word.
  task automatic test_backpressure();
    int i;
    hold_cycles = 400;
    for (i = 0; i < 40; i++)
      send_word(($urandom_range(0, 3) != 0) ? CMD_INSERT : CMD_POP_MIN, pick_value());
    wait_for_results();
  endtask

  // Random bursts biased to filling, emptying or neither, so the count
  // swings between both ends many times.
  task automatic test_random_mix(input int n_words);
    int         left;
    int         burst;
    int         bias;
    int         r;
    logic [1:0] cmd;
    left = n_words;
    while (left > 0) begin
      burst = $urandom_range(8, 50);
      bias  = $urandom_range(0, 2);
      if (burst > left) burst = left;
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (r < 3) cmd = CMD_UNUSED;
        else if (bias == 0) cmd = (r < 80) ? CMD_INSERT : (r[0] ? CMD_POP_MIN : CMD_POP_MAX);
        else if (bias == 1) cmd = (r < 25) ? CMD_INSERT : (r[0] ? CMD_POP_MIN : CMD_POP_MAX);
        else cmd = (r < 50) ? CMD_INSERT : (r[0] ? CMD_POP_MIN : CMD_POP_MAX);
        send_word(cmd, pick_value());
      end
      left = left - burst;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_store();
    test_extremes_and_ties();
    test_fill_and_overflow();
    test_backpressure();
    test_random_mix(1200);

    wait_for_results();
    repeat (64) @(posedge clk);

    errors = errors + pending_words.size();
    $display("Ran %0d command words, checked %0d result words", words_sent, words_seen);
    $display("Full-store inserts %0d, empty-store pops %0d, with long receiver hold-off",
             full_seen, empty_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sorted_double_ended_queue.f @@
hdl/sdq_pkg.sv
hdl/sdq_mem.sv
hdl/sdq_ctrl.sv
hdl/sorted_double_ended_queue.sv
dv/tb_sorted_double_ended_queue.sv
